### src/afd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package afd_pkg;

    // Register map, indexed by word address.
    localparam logic [1:0] REG_START_MARKER = 2'd0;
    localparam logic [1:0] REG_END_MARKER   = 2'd1;
    localparam logic [1:0] REG_BCAST_ADDR   = 2'd2;

    localparam logic [7:0]  START_MARKER_RST = 8'hAA;
    localparam logic [7:0]  END_MARKER_RST   = 8'hBB;
    localparam logic [31:0] BCAST_ADDR_RST   = 32'hFFFF_FFFF;

    // Byte positions inside a frame; zero means hunting for the start marker.
    localparam logic [3:0] POS_HUNT        = 4'd0;
    localparam logic [3:0] POS_FIRST_LAST  = 4'd4;
    localparam logic [3:0] POS_SECOND_LAST = 4'd8;
    localparam logic [3:0] POS_DATA_LAST   = 4'd12;
    localparam logic [3:0] POS_CLOSE       = 4'd13;

    typedef struct packed {
        logic [7:0]  start_marker;
        logic [7:0]  end_marker;
        logic [31:0] bcast_addr;
    } t_cfg;

    typedef struct packed {
        logic        frame_ok;
        logic        is_broadcast;
        logic [31:0] sender_address;
        logic [31:0] dest_address;
        logic [31:0] data_word;
    } t_result;

endpackage

`default_nettype wire

### src/afd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module afd_parser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_byte_vld,
    input  wire logic [7:0]       i_rx_byte,
    input  wire afd_pkg::t_cfg    i_cfg,
    output logic                  o_res_vld,
    output afd_pkg::t_result      o_res
);
    import afd_pkg::*;

    logic [3:0]  r_pos;
    logic [31:0] r_first;
    logic [31:0] r_second;
    logic [31:0] r_data;
    logic [31:0] r_held_dest;

    logic [3:0]  n_pos;
    logic [31:0] n_first;
    logic [31:0] n_second;
    logic [31:0] n_data;
    logic [31:0] n_held_dest;
    logic        w_bcast;

    assign w_bcast = (r_first == i_cfg.bcast_addr);

    always_comb begin
        n_pos       = r_pos;
        n_first     = r_first;
        n_second    = r_second;
        n_data      = r_data;
        n_held_dest = r_held_dest;
        o_res_vld   = 1'b0;
        o_res.frame_ok       = (i_rx_byte == i_cfg.end_marker);
        o_res.is_broadcast   = w_bcast;
        o_res.sender_address = w_bcast ? r_second : r_first;
        o_res.dest_address   = w_bcast ? r_held_dest : r_second;
        o_res.data_word      = r_data;
        if (i_byte_vld) begin
            // Fields arrive least significant byte first.
            if (r_pos == POS_HUNT || r_pos > POS_CLOSE) begin
                n_pos = (i_rx_byte == i_cfg.start_marker) ? 4'd1 : POS_HUNT;
            end else if (r_pos <= POS_FIRST_LAST) begin
                n_first = {i_rx_byte, r_first[31:8]};
                n_pos   = r_pos + 4'd1;
            end else if (r_pos <= POS_SECOND_LAST) begin
                n_second = {i_rx_byte, r_second[31:8]};
                n_pos    = r_pos + 4'd1;
            end else if (r_pos <= POS_DATA_LAST) begin
                n_data = {i_rx_byte, r_data[31:8]};
                n_pos  = r_pos + 4'd1;
            end else begin
                n_held_dest = o_res.dest_address;
                o_res_vld   = 1'b1;
                n_pos       = POS_HUNT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_HUNT;
            r_first     <= '0;
            r_second    <= '0;
            r_data      <= '0;
            r_held_dest <= '0;
        end else begin
            r_pos       <= n_pos;
            r_first     <= n_first;
            r_second    <= n_second;
            r_data      <= n_data;
            r_held_dest <= n_held_dest;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_CLOSE)
        else $error("frame position out of range");

    a_close_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_byte_vld && r_pos == POS_CLOSE) |=> (r_pos == POS_HUNT))
        else $error("closing byte did not return parser to hunting");

    a_held_on_bcast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_vld && w_bcast) |=> $stable(r_held_dest))
        else $error("held destination changed on a broadcast frame");

endmodule

`default_nettype wire

### src/addressed_frame_deframer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Addressed frame deframer. Received bytes enter one per request on the input
// channel; the block drops bytes until one equals the start marker, then
// collects thirteen more: a little-endian sender field, a little-endian second
// field, a little-endian data word and a closing byte. On the closing byte one
// result request is issued with frame_ok (closing byte matched the end marker),
// is_broadcast (sender field matched the broadcast address), the sender and
// destination addresses and the data word. On a broadcast frame the second
// field is reported as the sender and the destination repeats the last one
// seen; otherwise the second field becomes the new destination. A start marker
// inside a frame is plain data, and a bad closing byte still yields a result.
// Throughput is one byte per clock cycle while the skid register is empty;
// a result is registered on the output, or parks in skid if it is stalled.
// The output side holds an output register and one skid register, so the input
// keeps taking bytes while a result waits and o_ready depends only on state.
// Registers are written over the APB-style port: start marker at 0x0, end
// marker at 0x4, broadcast address at 0x8; 0xC is unused, paddr[1:0] ignored.

module addressed_frame_deframer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Byte input channel.
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_rx_byte,
    // Result output channel.
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_frame_ok,
    output logic             o_is_broadcast,
    output logic [31:0]      o_sender_address,
    output logic [31:0]      o_dest_address,
    output logic [31:0]      o_data_word,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import afd_pkg::*;

    t_cfg        r_cfg;
    logic        w_cfg_wr;
    logic [1:0]  w_reg_idx;

    t_result     w_res;
    logic        w_res_vld;
    logic        w_byte_acc;

    t_result     r_out;
    logic        r_out_vld;
    t_result     r_skid;
    logic        r_skid_vld;
    logic        w_out_take;

    // ------------------------------------------------------------------
    // Configuration registers. The port never stalls, so a write lands on
    // the access cycle.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker <= START_MARKER_RST;
            r_cfg.end_marker   <= END_MARKER_RST;
            r_cfg.bcast_addr   <= BCAST_ADDR_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_START_MARKER: r_cfg.start_marker <= pwdata[7:0];
                REG_END_MARKER:   r_cfg.end_marker   <= pwdata[7:0];
                REG_BCAST_ADDR:   r_cfg.bcast_addr   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_START_MARKER: prdata = {24'd0, r_cfg.start_marker};
            REG_END_MARKER:   prdata = {24'd0, r_cfg.end_marker};
            REG_BCAST_ADDR:   prdata = r_cfg.bcast_addr;
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Byte parser. A byte is taken whenever the skid register is free,
    // since that guarantees room for any result it may produce.
    // ------------------------------------------------------------------
    assign o_ready    = !r_skid_vld;
    assign w_byte_acc = i_valid && o_ready;

    afd_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_vld (w_byte_acc),
        .i_rx_byte  (i_rx_byte),
        .i_cfg      (r_cfg),
        .o_res_vld  (w_res_vld),
        .o_res      (w_res)
    );

    // ------------------------------------------------------------------
    // Output register with one skid entry. When the output register is
    // free or being drained, it reloads from the skid entry first, then
    // from a fresh result. A fresh result that meets a stalled output
    // parks in the skid entry.
    // ------------------------------------------------------------------
    assign w_out_take = r_out_vld && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (!r_out_vld || w_out_take) begin
                if (r_skid_vld) begin
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld <= w_res_vld;
                end
            end else if (w_res_vld) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || w_out_take) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
            end else if (w_res_vld) begin
                r_out <= w_res;
            end
        end else if (w_res_vld) begin
            r_skid <= w_res;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_frame_ok       = r_out.frame_ok;
    assign o_is_broadcast   = r_out.is_broadcast;
    assign o_sender_address = r_out.sender_address;
    assign o_dest_address   = r_out.dest_address;
    assign o_data_word      = r_out.data_word;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry holds a result while output register is empty");

    a_stall_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_ready && w_res_vld) |=> r_skid_vld)
        else $error("result lost while output was stalled");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && i_ready) |=> (!r_skid_vld && r_out_vld))
        else $error("skid entry did not move to output register");

endmodule

`default_nettype wire

### verif/afd_frame_checker.sv
`timescale 1ns / 1ps

module afd_frame_checker
    import afd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic        o_frame_ok,
    input  logic        o_is_broadcast,
    input  logic [31:0] o_sender_address,
    input  logic [31:0] o_dest_address,
    input  logic [31:0] o_data_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          o_mismatches,
    output int          o_outstanding,
    output int          o_frames,
    output int          o_broadcasts,
    output int          o_bad_closes
);

    t_cfg        regs;
    logic [3:0]  pos;
    logic [31:0] first_field;
    logic [31:0] second_field;
    logic [31:0] data_acc;
    logic [31:0] last_dest;
    t_result     pending_frames[$];

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
        o_frames      = 0;
        o_broadcasts  = 0;
        o_bad_closes  = 0;
    end

    // Only the first ten failures are printed; all of them are counted.
    task automatic flag(input string what);
        o_mismatches++;
        if (o_mismatches <= 10) begin
            $display("%0t checker: %s", $time, what);
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result frame;
        if (!i_rst_n) begin
            regs         = '{START_MARKER_RST, END_MARKER_RST, BCAST_ADDR_RST};
            pos          = POS_HUNT;
            first_field  = '0;
            second_field = '0;
            data_acc     = '0;
            last_dest    = '0;
            pending_frames.delete();
        end else begin
            // Byte parser: the register values current at this byte are used.
            if (i_valid && o_ready) begin
                if (pos == POS_HUNT || pos > POS_CLOSE) begin
                    pos = (i_rx_byte == regs.start_marker) ? POS_HUNT + 4'd1 : POS_HUNT;
                end else if (pos <= POS_FIRST_LAST) begin
                    first_field = {i_rx_byte, first_field[31:8]};
                    pos = pos + 4'd1;
                end else if (pos <= POS_SECOND_LAST) begin
                    second_field = {i_rx_byte, second_field[31:8]};
                    pos = pos + 4'd1;
                end else if (pos <= POS_DATA_LAST) begin
                    data_acc = {i_rx_byte, data_acc[31:8]};
                    pos = pos + 4'd1;
                end else begin
                    frame.frame_ok       = (i_rx_byte == regs.end_marker);
                    frame.is_broadcast   = (first_field == regs.bcast_addr);
                    frame.sender_address = frame.is_broadcast ? second_field : first_field;
                    if (!frame.is_broadcast) begin
                        last_dest = second_field;
                    end
                    frame.dest_address = last_dest;
                    frame.data_word    = data_acc;
                    pending_frames.push_back(frame);
                    if (frame.is_broadcast) o_broadcasts++;
                    if (!frame.frame_ok) o_bad_closes++;
                    pos = POS_HUNT;
                end
            end

            if (o_valid && i_ready) begin
                got = '{o_frame_ok, o_is_broadcast, o_sender_address,
                        o_dest_address, o_data_word};
                if (pending_frames.size() == 0) begin
                    flag($sformatf("result with none expected: ok=%0b bc=%0b snd=%h dst=%h data=%h",
                         got.frame_ok, got.is_broadcast, got.sender_address,
                         got.dest_address, got.data_word));
                end else begin
                    want = pending_frames.pop_front();
                    if (got.frame_ok !== want.frame_ok
                            || got.is_broadcast !== want.is_broadcast
                            || got.sender_address !== want.sender_address
                            || got.dest_address !== want.dest_address
                            || got.data_word !== want.data_word) begin
                        flag($sformatf({"frame %0d: expected ok=%0b bc=%0b snd=%h dst=%h data=%h,",
                             " got ok=%0b bc=%0b snd=%h dst=%h data=%h"}, o_frames,
                             want.frame_ok, want.is_broadcast, want.sender_address,
                             want.dest_address, want.data_word,
                             got.frame_ok, got.is_broadcast, got.sender_address,
                             got.dest_address, got.data_word));
                    end
                end
                o_frames++;
            end

            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[3:2])
                        REG_START_MARKER: regs.start_marker = pwdata[7:0];
                        REG_END_MARKER:   regs.end_marker   = pwdata[7:0];
                        REG_BCAST_ADDR:   regs.bcast_addr   = pwdata;
                        default:          ;
                    endcase
                end else begin
                    case (paddr[3:2])
                        REG_START_MARKER: begin
                            if (prdata[7:0] !== regs.start_marker) begin
                                flag($sformatf("start marker read %h, expected %h",
                                     prdata[7:0], regs.start_marker));
                            end
                        end
                        REG_END_MARKER: begin
                            if (prdata[7:0] !== regs.end_marker) begin
                                flag($sformatf("end marker read %h, expected %h",
                                     prdata[7:0], regs.end_marker));
                            end
                        end
                        REG_BCAST_ADDR: begin
                            if (prdata !== regs.bcast_addr) begin
                                flag($sformatf("broadcast address read %h, expected %h",
                                     prdata, regs.bcast_addr));
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
        o_outstanding = pending_frames.size();
    end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import afd_pkg::*;

    // Word index that maps to no register; writes there must be ignored.
    localparam logic [1:0] REG_SPARE = 2'd3;
    // Quiet period after the last predicted result has come out, so that
    // any byte still in flight can settle.
    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int BYTES_PER_PHASE = 240;
    localparam int N_PHASES        = 4;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_rx_byte = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_frame_ok;
    logic        o_is_broadcast;
    logic [31:0] o_sender_address;
    logic [31:0] o_dest_address;
    logic [31:0] o_data_word;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int outstanding;
    int frames;
    int broadcasts;
    int bad_closes;

    // Idle mixes per phase: none, sender mostly idle, receiver mostly stalled,
    // and both lightly idle.
    int send_idle_by_phase[N_PHASES]  = '{0, 74, 0, 15};
    int recv_stall_by_phase[N_PHASES] = '{0, 0, 74, 15};
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic rx_hold = 1'b0;
    int frame_bytes = 0;
    int reg_writes = 0;

    // Stimulus-side copy of the markers, needed to build frames.
    logic [7:0]  start_mk  = START_MARKER_RST;
    logic [7:0]  end_mk    = END_MARKER_RST;
    logic [31:0] bcast_val = BCAST_ADDR_RST;

    always #10 i_clk = ~i_clk;

    addressed_frame_deframer_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_frame_ok       (o_frame_ok),
        .o_is_broadcast   (o_is_broadcast),
        .o_sender_address (o_sender_address),
        .o_dest_address   (o_dest_address),
        .o_data_word      (o_data_word),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // The checker watches both channels and the register port, predicts each
    // result request and compares it; this module only drives stimulus.
    afd_frame_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_frame_ok       (o_frame_ok),
        .o_is_broadcast   (o_is_broadcast),
        .o_sender_address (o_sender_address),
        .o_dest_address   (o_dest_address),
        .o_data_word      (o_data_word),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_mismatches     (mismatches),
        .o_outstanding    (outstanding),
        .o_frames         (frames),
        .o_broadcasts     (broadcasts),
        .o_bad_closes     (bad_closes)
    );

    // Result receiver. The stall decision is redrawn every falling edge, and
    // the long hold-off overrides it. rx_hold only changes at rising edges, so
    // it is stable whenever this block reads it.
    always @(negedge i_clk) begin
        i_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Offers one byte request and returns at the falling edge after it was
    // accepted. Idle cycles are drawn one at a time before the request, so
    // gaps land on every byte position of a frame. Valid is never dropped
    // between back-to-back requests.
    task automatic put_byte(input logic [7:0] value, input bit counted);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= value;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        @(negedge i_clk);
        if (counted) frame_bytes++;
    endtask

    // A full frame: start marker, three little-endian words, closing byte.
    task automatic send_frame(input logic [31:0] first, input logic [31:0] second,
                              input logic [31:0] data, input logic [7:0] close);
        logic [95:0] body;
        body = {data, second, first};
        put_byte(start_mk, 1'b1);
        for (int k = 0; k < 12; k++) begin
            put_byte(body[8*k +: 8], 1'b1);
        end
        put_byte(close, 1'b1);
    endtask

    // Lowers valid, waits until every predicted result has come out, then
    // waits out the SETTLE_CYCLES quiet period so the parser is quiet before
    // any register write.
    task automatic settle();
        i_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Setup cycle, then access cycle; the bus is then left idle before return
    // so that psel never drops and rises in the same step.
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        reg_writes++;
        case (idx)
            REG_START_MARKER: start_mk  = value[7:0];
            REG_END_MARKER:   end_mk    = value[7:0];
            REG_BCAST_ADDR:   bcast_val = value;
            default:          ;
        endcase
    endtask

    // The checker compares prdata during the access cycle.
    task automatic apb_read(input logic [1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        int          target;
        int          roll;
        int          cut;
        logic [31:0] first;
        logic [7:0]  close;

        // Synchronous reset, held from time zero and released once.
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part with the reset register values. Two noise bytes at
        // the byte extremes are dropped while hunting. The first frame is an
        // ordinary addressed frame that carries the start marker inside its
        // data word, which must be taken as plain data. The second frame is a
        // broadcast with a wrong closing byte: it still yields a result, and
        // its destination must repeat the one from the first frame.
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b0);
        send_frame(32'h1234_5678, 32'h0000_0000, {8'h5C, start_mk, 8'h00, 8'hFF}, end_mk);
        send_frame(bcast_val, 32'hA5C3_0F11, 32'hFFFF_0000, ~end_mk);
        settle();
        apb_read(REG_START_MARKER);
        apb_read(REG_END_MARKER);
        apb_read(REG_BCAST_ADDR);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            send_idle_pct  = send_idle_by_phase[ph];
            recv_stall_pct = recv_stall_by_phase[ph];

            // Each phase runs under its own register setting; the markers
            // and the broadcast address go through their extremes. A write
            // to the unused address must leave everything as it is.
            case (ph)
                1: begin
                    apb_write(REG_START_MARKER, 32'h0000_0000);
                    apb_write(REG_END_MARKER, 32'h0000_00FF);
                    apb_write(REG_BCAST_ADDR, 32'h0000_0000);
                    apb_write(REG_SPARE, $urandom);
                end
                2: begin
                    apb_write(REG_START_MARKER, 32'h0000_00FF);
                    apb_write(REG_END_MARKER, 32'h0000_0000);
                    apb_write(REG_BCAST_ADDR, $urandom);
                end
                3: begin
                    apb_write(REG_START_MARKER, $urandom_range(255));
                    apb_write(REG_END_MARKER, $urandom_range(255));
                    apb_write(REG_BCAST_ADDR, 32'hFFFF_FFFF);
                end
                default: ;
            endcase
            if (ph != 0) begin
                apb_read(REG_START_MARKER);
                apb_read(REG_END_MARKER);
                apb_read(REG_BCAST_ADDR);
            end

            // Back-pressure: the receiver holds off for a long stretch while
            // the sender keeps offering frames, so the output and skid
            // registers fill and the byte input has to stall.
            if (ph == 0) begin
                fork
                    begin
                        @(posedge i_clk);
                        rx_hold = 1'b1;
                        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                        rx_hold = 1'b0;
                    end
                    repeat (12) send_frame($urandom, $urandom, $urandom, end_mk);
                join
            end

            // Random traffic: mostly well-formed frames with random content,
            // some noise between them, and now and then a frame cut short,
            // whose missing bytes are then taken from whatever follows.
            target = frame_bytes + BYTES_PER_PHASE;
            while (frame_bytes < target) begin
                repeat ($urandom_range(2)) put_byte(8'($urandom_range(255)), 1'b0);
                roll = $urandom_range(99);
                if (roll < 12) begin
                    cut = $urandom_range(1, 12);
                    put_byte(start_mk, 1'b1);
                    repeat (cut) put_byte(8'($urandom_range(255)), 1'b1);
                end else begin
                    roll = $urandom_range(99);
                    if (roll < 25) begin
                        first = bcast_val;
                    end else if (roll < 35) begin
                        first = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                    end else begin
                        first = $urandom;
                    end
                    close = ($urandom_range(99) < 85) ? end_mk : 8'($urandom_range(255));
                    send_frame(first, $urandom, $urandom, close);
                end
            end
            settle();
        end

        $display("Run covered %0d frames (%0d broadcast, %0d with a bad closing byte)",
                 frames, broadcasts, bad_closes);
        $display("from %0d frame bytes, four idle/stall mixes, a long hold-off, %0d reg writes.",
                 frame_bytes, reg_writes);
        if (mismatches == 0 && outstanding == 0) begin
            $display("** addressed_frame_deframer_unit: PASSED **");
        end else begin
            $display("** addressed_frame_deframer_unit: FAILED **");
        end
        $finish;
    end

    // Watchdog, far above the slowest expected run.
    initial begin
        #5_000_000;
        $display("** addressed_frame_deframer_unit: FAILED **");
        $finish;
    end

endmodule
